[src/cpt_pkg.sv]
// ----------------------------------------------------------------------------
// cpt_pkg
// shared types and constants of the coprimality test block
// ----------------------------------------------------------------------------
package cpt_pkg;

    // width of each operand field on the input stream
    localparam int FIELD_BITS           = 31;
    // two fields packed, padded up to whole bytes
    localparam int S_TDATA_BITS         = 64;
    localparam int M_TDATA_BITS         = 8;
    localparam int OPERAND_BITS_DEFAULT = 31;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_SWAP
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic div_start;
        logic div_step;
        logic swap;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic small_zero;
        logic small_one;
        logic div_done;
    } dp_status_t;

endpackage

[src/cpt_datapath.sv]
// ----------------------------------------------------------------------------
// cpt_datapath
// operand registers and a restoring bit-serial remainder unit
// ----------------------------------------------------------------------------
module cpt_datapath #(
    parameter int OPERAND_BITS = cpt_pkg::OPERAND_BITS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [cpt_pkg::FIELD_BITS-1:0]  first_value,
    input  logic [cpt_pkg::FIELD_BITS-1:0]  second_value,
    input  cpt_pkg::dp_cmd_t                cmd,
    output cpt_pkg::dp_status_t             status
);

    localparam int CNT_BITS = $clog2(OPERAND_BITS + 1);

    logic [OPERAND_BITS-1:0] a_op;
    logic [OPERAND_BITS-1:0] b_op;

    logic [OPERAND_BITS-1:0] big_reg;
    logic [OPERAND_BITS-1:0] big_next;
    logic [OPERAND_BITS-1:0] small_reg;
    logic [OPERAND_BITS-1:0] small_next;
    logic [OPERAND_BITS-1:0] rem_reg;
    logic [OPERAND_BITS-1:0] rem_next;
    logic [OPERAND_BITS-1:0] div_reg;
    logic [OPERAND_BITS-1:0] div_next;
    logic [CNT_BITS-1:0]     cnt_reg;
    logic [CNT_BITS-1:0]     cnt_next;

    logic [OPERAND_BITS:0]   shifted;
    logic [OPERAND_BITS:0]   diff;

    // operands are taken modulo 2^OPERAND_BITS
    generate
        if (OPERAND_BITS <= cpt_pkg::FIELD_BITS) begin : g_trunc
            assign a_op = first_value[OPERAND_BITS-1:0];
            assign b_op = second_value[OPERAND_BITS-1:0];
        end else begin : g_ext
            assign a_op = {{(OPERAND_BITS - cpt_pkg::FIELD_BITS){1'b0}}, first_value};
            assign b_op = {{(OPERAND_BITS - cpt_pkg::FIELD_BITS){1'b0}}, second_value};
        end
    endgenerate

    // one restoring step: bring in the next dividend bit, subtract if it fits
    assign shifted = {rem_reg, div_reg[OPERAND_BITS-1]};
    assign diff    = shifted - {1'b0, small_reg};

    always_comb
    begin
        big_next   = big_reg;
        small_next = small_reg;
        rem_next   = rem_reg;
        div_next   = div_reg;
        cnt_next   = cnt_reg;
        if (cmd.load)
        begin
            big_next   = (a_op >= b_op) ? a_op : b_op;
            small_next = (a_op >= b_op) ? b_op : a_op;
        end
        if (cmd.div_start)
        begin
            rem_next = '0;
            div_next = big_reg;
            cnt_next = CNT_BITS'(OPERAND_BITS);
        end
        if (cmd.div_step)
        begin
            rem_next = diff[OPERAND_BITS] ? shifted[OPERAND_BITS-1:0]
                                          : diff[OPERAND_BITS-1:0];
            div_next = {div_reg[OPERAND_BITS-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
        end
        if (cmd.swap)
        begin
            big_next   = small_reg;
            small_next = rem_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        big_reg   <= big_next;
        small_reg <= small_next;
        rem_reg   <= rem_next;
        div_reg   <= div_next;
    end

    assign status.small_zero = (small_reg == '0);
    assign status.small_one  = (small_reg == OPERAND_BITS'(1));
    assign status.div_done   = (cnt_reg == '0);

    a_rem_below_divisor : assert property (@(posedge clk) disable iff (!rst_n)
        cmd.swap |-> (rem_reg < small_reg))
        else $error("remainder not below divisor at swap");

    a_div_runs : assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |=> !status.div_done)
        else $error("divider done right after start");

    a_no_zero_divisor : assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> !status.small_zero)
        else $error("division step with zero divisor");

endmodule

[src/cpt_controller.sv]
// ----------------------------------------------------------------------------
// cpt_controller
// sequences the euclid steps and holds the result register
// ----------------------------------------------------------------------------
module cpt_controller (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                coprime,
    output cpt_pkg::dp_cmd_t    cmd,
    input  cpt_pkg::dp_status_t status
);

    cpt_pkg::state_t state_reg;
    cpt_pkg::state_t state_next;

    logic m_valid_reg;
    logic m_valid_next;
    logic coprime_reg;
    logic coprime_next;
    logic out_free;
    logic result_load;
    logic result_value;

    assign out_free = !m_valid_reg || m_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cpt_pkg::ST_IDLE:
            begin
                if (s_valid)
                begin
                    state_next = cpt_pkg::ST_CHECK;
                end
            end
            cpt_pkg::ST_CHECK:
            begin
                if (status.small_zero || status.small_one)
                begin
                    if (out_free)
                    begin
                        state_next = cpt_pkg::ST_IDLE;
                    end
                end
                else
                begin
                    state_next = cpt_pkg::ST_DIV;
                end
            end
            cpt_pkg::ST_DIV:
            begin
                if (status.div_done)
                begin
                    state_next = cpt_pkg::ST_SWAP;
                end
            end
            cpt_pkg::ST_SWAP:
            begin
                state_next = cpt_pkg::ST_CHECK;
            end
            default:
            begin
                state_next = cpt_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd          = '0;
        s_ready      = 1'b0;
        result_load  = 1'b0;
        result_value = 1'b0;
        case (state_reg)
            cpt_pkg::ST_IDLE:
            begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            cpt_pkg::ST_CHECK:
            begin
                if (status.small_zero || status.small_one)
                begin
                    result_load  = out_free;
                    result_value = !status.small_zero;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                end
            end
            cpt_pkg::ST_DIV:
            begin
                cmd.div_step = !status.div_done;
            end
            cpt_pkg::ST_SWAP:
            begin
                cmd.swap = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_comb
    begin
        m_valid_next = m_valid_reg;
        coprime_next = coprime_reg;
        if (m_valid_reg && m_ready)
        begin
            m_valid_next = 1'b0;
        end
        if (result_load)
        begin
            m_valid_next = 1'b1;
            coprime_next = result_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= cpt_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        coprime_reg <= coprime_next;
    end

    assign m_valid = m_valid_reg;
    assign coprime = coprime_reg;

    a_load_to_check : assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (state_reg == cpt_pkg::ST_CHECK))
        else $error("load not followed by check");

    a_zero_gives_zero : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == cpt_pkg::ST_CHECK && status.small_zero && out_free)
        |=> (m_valid_reg && !coprime_reg))
        else $error("zero remainder did not report not coprime");

endmodule

[src/coprimality_test_top.sv]
// ----------------------------------------------------------------------------
// coprimality_test_top
// coprimality check of two operands by euclidean remainder steps
// ----------------------------------------------------------------------------
// s_axis carries one operand pair per transaction, m_axis returns one result
// transaction per pair with the coprime flag in bit 0 of m_axis_tdata.
// the pair is ordered larger first; each euclid step tests the smaller
// operand, runs a bit-serial restoring divider through the dividend bits
// and then swaps, so that the remainder becomes the new smaller operand.
// when the smaller operand is 0 or 1 the result is ready with no division.
// the divider is the limit, and one pair is in work at a time:
// s_axis_tready is high only while the block is idle.
// the result sits in an output register; a new pair is accepted while it
// waits, but a finished result is held back until m_axis_tready frees it.
// reset empties the output register, clears the divider count and returns
// the controller to idle; there is no other state to clear.
// ----------------------------------------------------------------------------
module coprimality_test_top #(
    parameter int OPERAND_BITS = cpt_pkg::OPERAND_BITS_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [30:0] first_value, [61:31] second_value, [63:62] zero
    input  logic [cpt_pkg::S_TDATA_BITS-1:0]  s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [0] coprime, [7:1] zero
    output logic [cpt_pkg::M_TDATA_BITS-1:0]  m_axis_tdata
);

    cpt_pkg::dp_cmd_t    cmd;
    cpt_pkg::dp_status_t status;
    logic                coprime;

    cpt_datapath #(
        .OPERAND_BITS (OPERAND_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .first_value  (s_axis_tdata[cpt_pkg::FIELD_BITS-1:0]),
        .second_value (s_axis_tdata[2*cpt_pkg::FIELD_BITS-1:cpt_pkg::FIELD_BITS]),
        .cmd          (cmd),
        .status       (status)
    );

    cpt_controller u_controller (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .coprime (coprime),
        .cmd     (cmd),
        .status  (status)
    );

    assign m_axis_tdata = {{(cpt_pkg::M_TDATA_BITS-1){1'b0}}, coprime};

endmodule
